// File: rtl/pn2d_pkg.sv
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared constants, types and the gradient sine table for the 2-D noise block.
// ----------------------------------------------------------------------------
package pn2d_pkg;

  // Fixed-point formats.
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned INT_BITS   = 24;
  localparam int unsigned ANGLE_BITS = 10;
  localparam int unsigned COORD_W    = INT_BITS + FRAC_BITS;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned OUT_W      = 18;
  localparam int unsigned OUT_FRAC   = 16;
  localparam int unsigned IN_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned QUARTER    = 1 << (ANGLE_BITS - 2);

  // Working widths along the datapath.
  localparam int unsigned OFS_W  = FRAC_BITS + 1;  // corner offset, signed
  localparam int unsigned GRAD_W = FRAC_BITS + 2;  // gradient component, signed
  localparam int unsigned DOT_W  = FRAC_BITS + 3;  // corner dot product, signed
  localparam int unsigned LERP_W = FRAC_BITS + 4;  // blended value, signed
  localparam int unsigned PROD_W = LERP_W + 1 + FRAC_BITS + 1;

  // Hash multipliers and sine series constants.
  localparam logic [HASH_W-1:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [HASH_W-1:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [HASH_W-1:0] HASH_MUL_C = 32'd2048419325;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef logic [FRAC_BITS-1:0]             frac_t;
  typedef logic [ANGLE_BITS-1:0]            angle_t;
  typedef logic [FRAC_BITS:0]               sin_mag_t;
  typedef sin_mag_t [QUARTER:0]             sin_tab_t;
  typedef logic signed [OFS_W-1:0]          ofs_t;
  typedef logic signed [GRAD_W-1:0]         grad_t;
  typedef logic signed [DOT_W-1:0]          dot_t;
  typedef logic signed [LERP_W-1:0]         lerp_t;
  typedef logic [HASH_W-1:0]                hword_t;

  // Quarter-wave sine of (pi/2 * m / QUARTER), Q30 Taylor series in Horner form,
  // rounded to FRAC_BITS. Used only to build the constant table.
  function automatic sin_mag_t quarter_sin(logic [63:0] m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (PI_HALF_Q30 * m) >> (ANGLE_BITS - 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return s[FRAC_BITS:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int m = 0; m <= QUARTER; m++) begin
      tab[m] = quarter_sin(64'(m));
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Signed sine of angle k * 2pi / 2^ANGLE_BITS from the quarter-wave table.
  function automatic grad_t angle_sin(angle_t k);
    logic [1:0]            q;
    logic [ANGLE_BITS-3:0] r;
    logic [ANGLE_BITS-2:0] m;
    grad_t                 s;
    q = k[ANGLE_BITS-1 -: 2];
    r = k[ANGLE_BITS-3:0];
    m = q[0] ? ((ANGLE_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    s = grad_t'({1'b0, SIN_TAB[m]});
    return q[1] ? -s : s;
  endfunction

  function automatic hword_t rot16(hword_t v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

// File: rtl/pn2d_hash.sv
// ----------------------------------------------------------------------------
// pn2d_hash
// Three-stage corner hash: multiply, rotate and xor for the four cell corners.
// ----------------------------------------------------------------------------
module pn2d_hash (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  pn2d_pkg::hword_t        x0_i,
  input  pn2d_pkg::hword_t        y0_i,
  input  pn2d_pkg::frac_t         fx_i,
  input  pn2d_pkg::frac_t         fy_i,
  output logic                    valid_o,
  output pn2d_pkg::angle_t [3:0]  idx_o,
  output pn2d_pkg::frac_t         fx_o,
  output pn2d_pkg::frac_t         fy_o
);
  import pn2d_pkg::*;

  // Corner order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1).
  logic [2:0]       v_q;
  frac_t [2:0]      fx_q, fy_q;
  hword_t [1:0]     ax_q, ax_d;
  hword_t [1:0]     cy_q, cy_d;
  hword_t [3:0]     a_q, b_q, b_d;
  angle_t [3:0]     idx_q, idx_d;
  hword_t [3:0]     h;

  // Stage 1: first multiply on each x word.
  always_comb begin
    ax_d[0] = x0_i * HASH_MUL_A;
    ax_d[1] = (x0_i + 32'd1) * HASH_MUL_A;
    cy_d[0] = y0_i;
    cy_d[1] = y0_i + 32'd1;
  end

  // Stage 2: fold the y word in and multiply.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      b_d[c] = (cy_q[c / 2] ^ rot16(ax_q[c % 2])) * HASH_MUL_B;
    end
  end

  // Stage 3: fold back and take the top bits as the gradient angle.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h[c]     = (a_q[c] ^ rot16(b_q[c])) * HASH_MUL_C;
      idx_d[c] = h[c][HASH_W-1 -: ANGLE_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ax_q  <= ax_d;
      cy_q  <= cy_d;
      fx_q  <= {fx_q[1:0], fx_i};
      fy_q  <= {fy_q[1:0], fy_i};
      b_q   <= b_d;
      for (int c = 0; c < 4; c++) begin
        a_q[c] <= ax_q[c % 2];
      end
      idx_q <= idx_d;
    end
  end

  assign valid_o = v_q[2];
  assign idx_o   = idx_q;
  assign fx_o    = fx_q[2];
  assign fy_o    = fy_q[2];

endmodule

// File: rtl/pn2d_grad.sv
// ----------------------------------------------------------------------------
// pn2d_grad
// Gradient lookup and corner dot products, two register stages.
// ----------------------------------------------------------------------------
module pn2d_grad (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  pn2d_pkg::angle_t [3:0]  idx_i,
  input  pn2d_pkg::frac_t         fx_i,
  input  pn2d_pkg::frac_t         fy_i,
  output logic                    valid_o,
  output pn2d_pkg::dot_t [3:0]    dot_o,
  output pn2d_pkg::frac_t         fx_o,
  output pn2d_pkg::frac_t         fy_o
);
  import pn2d_pkg::*;

  localparam int unsigned SUM_W = OFS_W + GRAD_W + 1;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic [1:0]           v_q;
  frac_t [1:0]          fx_q, fy_q;
  grad_t [3:0]          gx_q, gy_q, gx_d, gy_d;
  ofs_t [3:0]           dx_q, dy_q, dx_d, dy_d;
  dot_t [3:0]           dot_q, dot_d;
  logic signed [SUM_W-1:0] sum [4];

  // Stage 1: sine table lookups and corner offsets.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      gx_d[c] = angle_sin(idx_i[c]);
      gy_d[c] = angle_sin(idx_i[c] + angle_t'(QUARTER));
      dx_d[c] = (c % 2 == 1) ? ofs_t'({1'b0, fx_i}) - (ofs_t'(1) <<< FRAC_BITS)
                             : ofs_t'({1'b0, fx_i});
      dy_d[c] = (c / 2 == 1) ? ofs_t'({1'b0, fy_i}) - (ofs_t'(1) <<< FRAC_BITS)
                             : ofs_t'({1'b0, fy_i});
    end
  end

  // Stage 2: dot product, rounded half up to FRAC_BITS.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c]   = SUM_W'(dx_q[c]) * SUM_W'(gx_q[c]) + SUM_W'(dy_q[c]) * SUM_W'(gy_q[c]);
      sum[c]   = (sum[c] + HALF) >>> FRAC_BITS;
      dot_d[c] = sum[c][DOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      gx_q  <= gx_d;
      gy_q  <= gy_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      dot_q <= dot_d;
      fx_q  <= {fx_q[0], fx_i};
      fy_q  <= {fy_q[0], fy_i};
    end
  end

  assign valid_o = v_q[1];
  assign dot_o   = dot_q;
  assign fx_o    = fx_q[1];
  assign fy_o    = fy_q[1];

endmodule

// File: rtl/pn2d_lerp.sv
// ----------------------------------------------------------------------------
// pn2d_lerp
// Two-level linear blend along x then y, rounding and saturation to Q2.16.
// ----------------------------------------------------------------------------
module pn2d_lerp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  pn2d_pkg::dot_t [3:0]        dot_i,
  input  pn2d_pkg::frac_t             fx_i,
  input  pn2d_pkg::frac_t             fy_i,
  output logic                        valid_o,
  output logic signed [pn2d_pkg::OUT_W-1:0] noise_o
);
  import pn2d_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;
  localparam prod_t HALF    = prod_t'(1) <<< (FRAC_BITS - 1);
  localparam prod_t OUT_MAX = (prod_t'(1) <<< (OUT_W - 1)) - prod_t'(1);
  localparam prod_t OUT_MIN = -(prod_t'(1) <<< (OUT_W - 1));

  logic [3:0]       v_q;
  prod_t [1:0]      px_q, px_d;
  lerp_t [1:0]      ax_q;
  frac_t [1:0]      fy_q;
  lerp_t [1:0]      r_q, r_d;
  prod_t            py_q, py_d;
  lerp_t            r0_q;
  prod_t            v_full;
  logic signed [OUT_W-1:0] out_q, out_d;

  // Stage 1: (b - a) * fx for both rows.
  always_comb begin
    px_d[0] = (prod_t'(dot_i[1]) - prod_t'(dot_i[0])) * prod_t'({1'b0, fx_i});
    px_d[1] = (prod_t'(dot_i[3]) - prod_t'(dot_i[2])) * prod_t'({1'b0, fx_i});
  end

  // Stage 2: add the rounded step to each row's start.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      r_d[k] = lerp_t'(prod_t'(ax_q[k]) + ((px_q[k] + HALF) >>> FRAC_BITS));
    end
  end

  // Stage 3: (r1 - r0) * fy.
  assign py_d = (prod_t'(r_q[1]) - prod_t'(r_q[0])) * prod_t'({1'b0, fy_q[1]});

  // Stage 4: final blend and saturation; FRAC_BITS equals the output fraction.
  always_comb begin
    v_full = prod_t'(r0_q) + ((py_q + HALF) >>> FRAC_BITS);
    if (v_full > OUT_MAX) begin
      out_d = OUT_MAX[OUT_W-1:0];
    end else if (v_full < OUT_MIN) begin
      out_d = OUT_MIN[OUT_W-1:0];
    end else begin
      out_d = v_full[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q    <= px_d;
      ax_q[0] <= lerp_t'(dot_i[0]);
      ax_q[1] <= lerp_t'(dot_i[2]);
      fy_q    <= {fy_q[0], fy_i};
      r_q     <= r_d;
      py_q    <= py_d;
      r0_q    <= r_q[0];
      out_q   <= out_d;
    end
  end

  assign valid_o = v_q[3];
  assign noise_o = out_q;

endmodule

// File: rtl/perlin_noise_2d.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d
// 2-D gradient noise: one Q24.16 point in, one saturated Q2.16 value out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[39:0] x_coord, tdata[79:40] y_coord
//  m_axis    out        tdata[17:0] noise_value, upper bits zero
//
//  One item per cycle unless m_axis stalls; the output is registered.
//  Stages: input split, three hash stages, lookup, dot, four blend stages.
//  Reset clears only the valid bits; the datapath registers are not reset.
//  A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module perlin_noise_2d (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pn2d_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // x_coord, y_coord
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pn2d_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // noise_value
);
  import pn2d_pkg::*;

  logic                   adv;
  logic                   v0_q;
  hword_t                 x0_q, y0_q, x0_d, y0_d;
  frac_t                  fx_q, fy_q;
  logic [INT_BITS-1:0]    xi, yi;
  logic                   h_valid, g_valid, l_valid;
  angle_t [3:0]           h_idx;
  frac_t                  h_fx, h_fy, g_fx, g_fy;
  dot_t [3:0]             g_dot;
  logic signed [OUT_W-1:0] noise;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv           = !l_valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input stage: floor to the cell and sign-extend to the hash word.
  always_comb begin
    xi   = s_axis_tdata[COORD_W-1:FRAC_BITS];
    yi   = s_axis_tdata[2*COORD_W-1:COORD_W+FRAC_BITS];
    x0_d = HASH_W'(signed'(xi));
    y0_d = HASH_W'(signed'(yi));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      fx_q <= s_axis_tdata[FRAC_BITS-1:0];
      fy_q <= s_axis_tdata[COORD_W+FRAC_BITS-1:COORD_W];
    end
  end

  pn2d_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v0_q),
    .x0_i    (x0_q),
    .y0_i    (y0_q),
    .fx_i    (fx_q),
    .fy_i    (fy_q),
    .valid_o (h_valid),
    .idx_o   (h_idx),
    .fx_o    (h_fx),
    .fy_o    (h_fy)
  );

  pn2d_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (h_valid),
    .idx_i   (h_idx),
    .fx_i    (h_fx),
    .fy_i    (h_fy),
    .valid_o (g_valid),
    .dot_o   (g_dot),
    .fx_o    (g_fx),
    .fy_o    (g_fy)
  );

  pn2d_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (g_valid),
    .dot_i   (g_dot),
    .fx_i    (g_fx),
    .fy_i    (g_fy),
    .valid_o (l_valid),
    .noise_o (noise)
  );

  assign m_axis_tvalid = l_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, noise};

endmodule
